// ----- rtl/core/dalm_pkg.sv -----
// dalm_pkg: types, form codes and the form decode table for the
// attribute length measure. No dependencies.
package dalm_pkg;

    localparam int unsigned LEB_IDX_W = 4;
    localparam int unsigned ACC_W     = 35;
    localparam int unsigned LEN_W     = 36;

    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNKNOWN  = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    localparam logic CFG_OFFSET_64 = 1'b0;
    localparam logic CFG_ADDR_SIZE = 1'b1;

    localparam logic [15:0] FORM_ADDR       = 16'h01;
    localparam logic [15:0] FORM_BLOCK2     = 16'h03;
    localparam logic [15:0] FORM_BLOCK4     = 16'h04;
    localparam logic [15:0] FORM_DATA2      = 16'h05;
    localparam logic [15:0] FORM_DATA4      = 16'h06;
    localparam logic [15:0] FORM_DATA8      = 16'h07;
    localparam logic [15:0] FORM_STRING     = 16'h08;
    localparam logic [15:0] FORM_BLOCK      = 16'h09;
    localparam logic [15:0] FORM_BLOCK1     = 16'h0a;
    localparam logic [15:0] FORM_DATA1      = 16'h0b;
    localparam logic [15:0] FORM_FLAG       = 16'h0c;
    localparam logic [15:0] FORM_SDATA      = 16'h0d;
    localparam logic [15:0] FORM_STRP       = 16'h0e;
    localparam logic [15:0] FORM_UDATA      = 16'h0f;
    localparam logic [15:0] FORM_REF_ADDR   = 16'h10;
    localparam logic [15:0] FORM_REF1       = 16'h11;
    localparam logic [15:0] FORM_REF2       = 16'h12;
    localparam logic [15:0] FORM_REF4       = 16'h13;
    localparam logic [15:0] FORM_REF8       = 16'h14;
    localparam logic [15:0] FORM_REF_UDATA  = 16'h15;
    localparam logic [15:0] FORM_INDIRECT   = 16'h16;
    localparam logic [15:0] FORM_SEC_OFFSET = 16'h17;
    localparam logic [15:0] FORM_EXPRLOC    = 16'h18;
    localparam logic [15:0] FORM_FLAG_PRES  = 16'h19;
    localparam logic [15:0] FORM_STRX       = 16'h1a;
    localparam logic [15:0] FORM_ADDRX      = 16'h1b;
    localparam logic [15:0] FORM_REF_SUP4   = 16'h1c;
    localparam logic [15:0] FORM_STRP_SUP   = 16'h1d;
    localparam logic [15:0] FORM_DATA16     = 16'h1e;
    localparam logic [15:0] FORM_LINE_STRP  = 16'h1f;
    localparam logic [15:0] FORM_REF_SIG8   = 16'h20;
    localparam logic [15:0] FORM_IMPL_CONST = 16'h21;
    localparam logic [15:0] FORM_LOCLISTX   = 16'h22;
    localparam logic [15:0] FORM_RNGLISTX   = 16'h23;
    localparam logic [15:0] FORM_REF_SUP8   = 16'h24;
    localparam logic [15:0] FORM_STRX1      = 16'h25;
    localparam logic [15:0] FORM_STRX2      = 16'h26;
    localparam logic [15:0] FORM_STRX3      = 16'h27;
    localparam logic [15:0] FORM_STRX4      = 16'h28;
    localparam logic [15:0] FORM_ADDRX1     = 16'h29;
    localparam logic [15:0] FORM_ADDRX2     = 16'h2a;
    localparam logic [15:0] FORM_ADDRX3     = 16'h2b;
    localparam logic [15:0] FORM_ADDRX4     = 16'h2c;

    typedef enum logic [5:0] {
        PH_IDLE        = 6'b000001,
        PH_LEB         = 6'b000010,
        PH_BLOCK_LEB   = 6'b000100,
        PH_INDIRECT    = 6'b001000,
        PH_STRING      = 6'b010000,
        PH_BLOCK_FIXED = 6'b100000
    } t_phase;

    typedef struct packed {
        t_phase                 phase;
        logic [31:0]            prefix;
        logic [ACC_W-1:0]       acc;
        logic                   big;
        logic [LEB_IDX_W-1:0]   idx;
        logic [2:0]             size_left;
    } t_state;

    typedef struct packed {
        logic        emit;
        logic        unknown;
        logic [4:0]  len;
        t_phase      phase;
        logic [2:0]  size_left;
    } t_disp;

    function automatic t_disp form_decode(input logic [15:0] form, input logic off64,
                                          input logic [3:0] addr_size);
        t_disp d;
        d.emit      = 1'b1;
        d.unknown   = 1'b0;
        d.len       = 5'd0;
        d.phase     = PH_IDLE;
        d.size_left = 3'd0;
        case (form)
            FORM_FLAG_PRES, FORM_IMPL_CONST: d.len = 5'd0;
            FORM_DATA1, FORM_FLAG, FORM_STRX1, FORM_REF1, FORM_ADDRX1: d.len = 5'd1;
            FORM_DATA2, FORM_REF2, FORM_STRX2, FORM_ADDRX2: d.len = 5'd2;
            FORM_STRX3, FORM_ADDRX3: d.len = 5'd3;
            FORM_STRX4, FORM_ADDRX4, FORM_DATA4, FORM_REF_SUP4, FORM_REF4: d.len = 5'd4;
            FORM_REF8, FORM_REF_SIG8, FORM_DATA8, FORM_REF_SUP8: d.len = 5'd8;
            FORM_DATA16: d.len = 5'd16;
            FORM_STRP, FORM_REF_ADDR, FORM_SEC_OFFSET, FORM_STRP_SUP, FORM_LINE_STRP:
                d.len = off64 ? 5'd8 : 5'd4;
            FORM_ADDR: d.len = {1'b0, addr_size};
            FORM_SDATA, FORM_UDATA, FORM_STRX, FORM_ADDRX, FORM_REF_UDATA,
            FORM_LOCLISTX, FORM_RNGLISTX: begin
                d.emit  = 1'b0;
                d.phase = PH_LEB;
            end
            FORM_BLOCK, FORM_EXPRLOC: begin
                d.emit  = 1'b0;
                d.phase = PH_BLOCK_LEB;
            end
            FORM_STRING: begin
                d.emit  = 1'b0;
                d.phase = PH_STRING;
            end
            FORM_BLOCK1: begin
                d.emit      = 1'b0;
                d.phase     = PH_BLOCK_FIXED;
                d.size_left = 3'd1;
            end
            FORM_BLOCK2: begin
                d.emit      = 1'b0;
                d.phase     = PH_BLOCK_FIXED;
                d.size_left = 3'd2;
            end
            FORM_BLOCK4: begin
                d.emit      = 1'b0;
                d.phase     = PH_BLOCK_FIXED;
                d.size_left = 3'd4;
            end
            FORM_INDIRECT: begin
                d.emit  = 1'b0;
                d.phase = PH_INDIRECT;
            end
            default: d.unknown = 1'b1;
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/core/dalm_step.sv -----
// dalm_step: next-state and result logic for one beat of the length measure.
// Depends on dalm_pkg.
module dalm_step #(
    parameter int unsigned MAX_LEB_BYTES = 10
) (
    input  dalm_pkg::t_state  i_state,
    input  logic              i_opcode,
    input  logic [15:0]       i_form_code,
    input  logic [7:0]        i_data_byte,
    input  logic              i_off64,
    input  logic [3:0]        i_addr_size,
    output dalm_pkg::t_state  o_state,
    output logic              o_emit,
    output logic [31:0]       o_value_length,
    output logic [1:0]        o_status
);

    dalm_pkg::t_state                    s;
    dalm_pkg::t_disp                     d;
    logic [6:0]                          pay;
    logic [dalm_pkg::ACC_W-1:0]          leb_acc;
    logic                                leb_big;
    logic [dalm_pkg::LEB_IDX_W-1:0]      leb_idx;
    logic                                leb_done;
    logic [32:0]                         pre_sum;
    logic [31:0]                         pre_ind;
    logic                                ind_big;
    logic [dalm_pkg::ACC_W-1:0]          str_cnt;
    logic [dalm_pkg::ACC_W-1:0]          bf_acc;
    logic [2:0]                          bf_left;
    logic                                do_disp;
    logic [31:0]                         disp_pre;
    logic                                emit;
    logic                                unknown;
    logic                                len_big;
    logic [dalm_pkg::LEN_W-1:0]          len;
    logic [31:0]                         pre;
    logic [dalm_pkg::LEN_W:0]            total;
    logic                                too_long;

    assign s   = i_state;
    assign pay = i_data_byte[6:0];

    always_comb begin
        leb_acc = s.acc;
        leb_big = s.big;
        case (s.idx)
            4'd0: leb_acc[6:0]   = s.acc[6:0]   | pay;
            4'd1: leb_acc[13:7]  = s.acc[13:7]  | pay;
            4'd2: leb_acc[20:14] = s.acc[20:14] | pay;
            4'd3: leb_acc[27:21] = s.acc[27:21] | pay;
            4'd4: leb_acc[34:28] = s.acc[34:28] | pay;
            default: begin
                if (pay != 7'd0) begin
                    leb_big = 1'b1;
                end
            end
        endcase
        leb_idx  = s.idx + 4'd1;
        leb_done = !i_data_byte[7] || (leb_idx >= dalm_pkg::LEB_IDX_W'(MAX_LEB_BYTES));
    end

    always_comb begin
        bf_acc = s.acc;
        case (s.idx)
            4'd0: bf_acc[7:0]   = s.acc[7:0]   | i_data_byte;
            4'd1: bf_acc[15:8]  = s.acc[15:8]  | i_data_byte;
            4'd2: bf_acc[23:16] = s.acc[23:16] | i_data_byte;
            4'd3: bf_acc[31:24] = s.acc[31:24] | i_data_byte;
            default: bf_acc = s.acc;
        endcase
        bf_left = (s.size_left != 3'd0) ? s.size_left - 3'd1 : 3'd0;
    end

    assign pre_sum = {1'b0, s.prefix} + 33'(leb_idx);
    assign pre_ind = pre_sum[32] ? 32'hFFFF_FFFF : pre_sum[31:0];
    assign ind_big = leb_big || (leb_acc[dalm_pkg::ACC_W-1:16] != '0);
    assign str_cnt = s.acc[32] ? s.acc : s.acc + dalm_pkg::ACC_W'(1);
    assign d = dalm_pkg::form_decode((i_opcode == dalm_pkg::OP_BEGIN) ? i_form_code
                                     : leb_acc[15:0], i_off64, i_addr_size);

    always_comb begin
        o_state  = s;
        do_disp  = 1'b0;
        disp_pre = 32'd0;
        emit     = 1'b0;
        unknown  = 1'b0;
        len_big  = 1'b0;
        len      = '0;
        pre      = s.prefix;
        if (i_opcode == dalm_pkg::OP_BEGIN) begin
            do_disp = 1'b1;
        end else begin
            case (s.phase)
                dalm_pkg::PH_LEB: begin
                    o_state.acc = leb_acc;
                    o_state.big = leb_big;
                    o_state.idx = leb_idx;
                    if (leb_done) begin
                        emit = 1'b1;
                        len  = dalm_pkg::LEN_W'(leb_idx);
                    end
                end
                dalm_pkg::PH_BLOCK_LEB: begin
                    o_state.acc = leb_acc;
                    o_state.big = leb_big;
                    o_state.idx = leb_idx;
                    if (leb_done) begin
                        emit    = 1'b1;
                        len_big = leb_big;
                        len     = dalm_pkg::LEN_W'(leb_acc) + dalm_pkg::LEN_W'(leb_idx);
                    end
                end
                dalm_pkg::PH_INDIRECT: begin
                    o_state.acc = leb_acc;
                    o_state.big = leb_big;
                    o_state.idx = leb_idx;
                    if (leb_done) begin
                        if (ind_big) begin
                            emit    = 1'b1;
                            unknown = 1'b1;
                        end else begin
                            do_disp  = 1'b1;
                            disp_pre = pre_ind;
                        end
                    end
                end
                dalm_pkg::PH_STRING: begin
                    o_state.acc = str_cnt;
                    if (i_data_byte == 8'd0) begin
                        emit = 1'b1;
                        len  = dalm_pkg::LEN_W'(str_cnt);
                    end
                end
                dalm_pkg::PH_BLOCK_FIXED: begin
                    o_state.acc       = bf_acc;
                    o_state.idx       = s.idx + 4'd1;
                    o_state.size_left = bf_left;
                    if (bf_left == 3'd0) begin
                        emit = 1'b1;
                        len  = dalm_pkg::LEN_W'(bf_acc) + dalm_pkg::LEN_W'(s.idx + 4'd1);
                    end
                end
                default: o_state = s;
            endcase
        end
        if (do_disp) begin
            pre               = disp_pre;
            o_state.phase     = d.phase;
            o_state.prefix    = disp_pre;
            o_state.acc       = '0;
            o_state.big       = 1'b0;
            o_state.idx       = '0;
            o_state.size_left = d.size_left;
            emit              = d.emit;
            unknown           = d.unknown;
            len               = dalm_pkg::LEN_W'(d.len);
        end
        if (emit) begin
            o_state.phase     = dalm_pkg::PH_IDLE;
            o_state.prefix    = 32'd0;
            o_state.acc       = '0;
            o_state.big       = 1'b0;
            o_state.idx       = '0;
            o_state.size_left = 3'd0;
        end
    end

    assign total    = (dalm_pkg::LEN_W + 1)'(pre) + (dalm_pkg::LEN_W + 1)'(len);
    assign too_long = len_big || (total[dalm_pkg::LEN_W:32] != '0);

    always_comb begin
        o_emit = emit;
        if (unknown) begin
            o_value_length = 32'd0;
            o_status       = dalm_pkg::ST_UNKNOWN;
        end else if (too_long) begin
            o_value_length = 32'hFFFF_FFFF;
            o_status       = dalm_pkg::ST_TOO_LONG;
        end else begin
            o_value_length = total[31:0];
            o_status       = dalm_pkg::ST_OK;
        end
    end

endmodule

// ----- rtl/core/dwarf_attribute_length_measure.sv -----
// dwarf_attribute_length_measure: top level of the attribute length measure.
// Depends on dalm_pkg and dalm_step.
//
//  channel | direction | handshake               | payload
//  in      | sink      | i_in_valid / o_in_stall | i_opcode, i_form_code, i_data_byte
//  out     | source    | o_out_valid/i_out_stall | o_value_length, o_status
//  cfg     | sink      | i_cfg_we                | i_cfg_index, i_cfg_data
//
// One beat per cycle unless stalled; the beat that ends a result passes the input register,
// then the step logic into the result register.
// The measure state updates once per beat from the input register.
// Synchronous active-low reset; no clearing pass.
// Out stall holds the result register and, once the input register is full, the input.
module dwarf_attribute_length_measure #(
    parameter int unsigned MAX_LEB_BYTES = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [15:0] i_form_code,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_value_length,
    output logic [1:0]  o_status,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_data
);

    logic              r_in_valid;
    logic              r_in_op;
    logic [15:0]       r_in_form;
    logic [7:0]        r_in_byte;
    dalm_pkg::t_state  r_state;
    dalm_pkg::t_state  n_state;
    logic              r_out_valid;
    logic [31:0]       r_out_len;
    logic [1:0]        r_out_status;
    logic              r_off64;
    logic [3:0]        r_addr_size;

    logic              advance;
    logic              in_ready;
    logic              step_emit;
    logic [31:0]       step_len;
    logic [1:0]        step_status;

    assign advance  = !r_out_valid || !i_out_stall;
    assign in_ready = !r_in_valid || advance;

    dalm_step #(
        .MAX_LEB_BYTES(MAX_LEB_BYTES)
    ) u_step (
        .i_state        (r_state),
        .i_opcode       (r_in_op),
        .i_form_code    (r_in_form),
        .i_data_byte    (r_in_byte),
        .i_off64        (r_off64),
        .i_addr_size    (r_addr_size),
        .o_state        (n_state),
        .o_emit         (step_emit),
        .o_value_length (step_len),
        .o_status       (step_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_off64           <= 1'b0;
            r_addr_size       <= 4'd8;
            r_state.phase     <= dalm_pkg::PH_IDLE;
            r_state.prefix    <= 32'd0;
            r_state.acc       <= '0;
            r_state.big       <= 1'b0;
            r_state.idx       <= '0;
            r_state.size_left <= 3'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    dalm_pkg::CFG_OFFSET_64: r_off64     <= i_cfg_data[0];
                    dalm_pkg::CFG_ADDR_SIZE: r_addr_size <= i_cfg_data;
                    default: r_off64 <= r_off64;
                endcase
            end
            if (in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (r_in_valid && advance) begin
                r_state <= n_state;
            end
            if (advance) begin
                r_out_valid <= r_in_valid && step_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready) begin
            r_in_op   <= i_opcode;
            r_in_form <= i_form_code;
            r_in_byte <= i_data_byte;
        end
        if (advance) begin
            r_out_len    <= step_len;
            r_out_status <= step_status;
        end
    end

    assign o_in_stall     = !in_ready;
    assign o_out_valid    = r_out_valid;
    assign o_value_length = r_out_len;
    assign o_status       = r_out_status;

endmodule

// ----- rtl/core/dalm_check.sv -----
// dalm_check: port-level checks for dwarf_attribute_length_measure, bound to it.
// Depends on dalm_pkg.
module dalm_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_in_stall,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] o_value_length,
    input  logic [1:0]  o_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_value_length) && $stable(o_status))
        else $error("result changed while stalled");

    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == dalm_pkg::ST_UNKNOWN) |-> o_value_length == 32'd0)
        else $error("unknown form with nonzero length");

    a_too_long_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == dalm_pkg::ST_TOO_LONG) |->
            o_value_length == 32'hFFFF_FFFF)
        else $error("overlong length not saturated");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind dwarf_attribute_length_measure dalm_check u_dalm_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_value_length (o_value_length),
    .o_status       (o_status)
);
